@@ rtl/b5mv_pkg.sv @@
`default_nettype none

package b5mv_pkg;

  // Largest matrix order the stores hold.
  localparam int unsigned MaxOrder = 1024;
  localparam int unsigned AddrW    = $clog2(MaxOrder);
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  // Five exact products need three bits of headroom above the product width.
  localparam int unsigned AccW     = ProdW + 3;
  localparam int unsigned OrderW   = 11;
  localparam int unsigned OffsetW  = 10;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned RowW      = 10;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 80;

  localparam logic [CfgIdxW-1:0] RegRowCount  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFarOffset = 1'b1;

  localparam int unsigned TermW = 3;
  localparam logic [TermW-1:0] TermFarLow  = 3'd0;
  localparam logic [TermW-1:0] TermFarHigh = 3'd1;
  localparam logic [TermW-1:0] TermNearLow = 3'd2;
  localparam logic [TermW-1:0] TermNearHigh = 3'd3;
  localparam logic [TermW-1:0] TermMain    = 3'd4;

  typedef enum logic [CmdW-1:0] {
    CmdMain    = 3'd0,
    CmdNear    = 3'd1,
    CmdFar     = 3'd2,
    CmdVector  = 3'd3,
    CmdCompute = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    BandMain = 2'd0,
    BandNear = 2'd1,
    BandFar  = 2'd2
  } band_e;

  typedef struct packed {
    logic             en;
    cmd_e             cmd;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    band_e            band;
    logic [AddrW-1:0] band_addr;
    logic [AddrW-1:0] vec_addr;
  } rd_req_t;

  typedef struct packed {
    logic valid;
    logic en;
    logic first;
    logic last;
  } term_t;

endpackage

`default_nettype wire

@@ rtl/band5_matrix_vector_product_core.sv @@
`default_nettype none

// Five-diagonal symmetric band matrix times vector. The main diagonal, the
// diagonals at offset one and the diagonals at offset k are each kept in a
// 1024-entry single-port memory, and the vector in a fourth. A request whose
// tuser is a load command (main, near, far or vector entry) writes one entry;
// a compute request names row i and, when i is below the matrix order,
// returns y[i] as a saturated signed Q32.32 value. Terms outside the matrix
// are skipped. A sequencer issues the five terms of a compute, one read of
// the vector memory and one of a band memory per cycle; the registered reads,
// the product register, the accumulator and the output register follow in
// that order. The block becomes ready for the next request once the result
// is registered. The block holds one compute at a time; a finished result
// waits in the output register while the next request is taken.
// Configuration (row_count at index 0, far_offset at index 1) may be written
// only while the block is idle. Stores are not cleared at reset; every entry
// a compute uses must have been loaded first.
module band5_matrix_vector_product_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic     [b5mv_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic     [b5mv_pkg::CfgDataW-1:0]   cfg_data_i,
  // Request stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: index [9:0], value [41:10], zero fill up to bit 47.
  input  wire logic     [b5mv_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: command [2:0].
  input  wire logic     [b5mv_pkg::CmdW-1:0]       s_axis_tuser,
  // Result stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: row_index [9:0], row_value [73:10], zero fill up to bit 79.
  output logic     [b5mv_pkg::OutDataW-1:0]        m_axis_tdata
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StIssue = 4'b0010,
    StDrain = 4'b0100,
    StHold  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [b5mv_pkg::OrderW-1:0]  row_count_q;
  logic [b5mv_pkg::OffsetW-1:0] far_offset_q;

  // Configuration registers are taken as written; clamping happens at use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q  <= b5mv_pkg::OrderW'(b5mv_pkg::MaxOrder);
      far_offset_q <= b5mv_pkg::OffsetW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        b5mv_pkg::RegRowCount:  row_count_q  <= cfg_data_i;
        b5mv_pkg::RegFarOffset: far_offset_q <= cfg_data_i[b5mv_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // Effective order n in 1..MaxOrder and offset k of at least two.
  logic [b5mv_pkg::OrderW-1:0]  n_eff;
  logic [b5mv_pkg::OffsetW-1:0] k_eff;

  always_comb begin
    if (row_count_q == '0) begin
      n_eff = b5mv_pkg::OrderW'(1);
    end else if (row_count_q > b5mv_pkg::OrderW'(b5mv_pkg::MaxOrder)) begin
      n_eff = b5mv_pkg::OrderW'(b5mv_pkg::MaxOrder);
    end else begin
      n_eff = row_count_q;
    end
    k_eff = (far_offset_q < b5mv_pkg::OffsetW'(2)) ? b5mv_pkg::OffsetW'(2) : far_offset_q;
  end

  // Request decode.
  b5mv_pkg::cmd_e                 in_cmd;
  logic [b5mv_pkg::RowW-1:0]      in_idx;
  logic [b5mv_pkg::DataW-1:0]     in_val;
  logic                           in_acc;
  logic [b5mv_pkg::OrderW-1:0]    idx_ext;
  logic                           row_ok;
  logic [4:0]                     en_d;

  assign in_cmd  = b5mv_pkg::cmd_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[b5mv_pkg::RowW-1:0];
  assign in_val  = s_axis_tdata[b5mv_pkg::RowW +: b5mv_pkg::DataW];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign idx_ext = {1'b0, in_idx};
  assign row_ok  = idx_ext < n_eff;

  // Which of the five terms lie inside the matrix for the requested row.
  always_comb begin
    en_d[b5mv_pkg::TermFarLow]   = in_idx >= k_eff;
    en_d[b5mv_pkg::TermFarHigh]  = (idx_ext + {1'b0, k_eff}) < n_eff;
    en_d[b5mv_pkg::TermNearLow]  = in_idx != '0;
    en_d[b5mv_pkg::TermNearHigh] = (idx_ext + b5mv_pkg::OrderW'(1)) < n_eff;
    en_d[b5mv_pkg::TermMain]     = 1'b1;
  end

  b5mv_pkg::wr_req_t wr_req;

  always_comb begin
    wr_req.en   = in_acc && (in_cmd inside {b5mv_pkg::CmdMain, b5mv_pkg::CmdNear,
                                            b5mv_pkg::CmdFar, b5mv_pkg::CmdVector});
    wr_req.cmd  = in_cmd;
    wr_req.addr = in_idx[b5mv_pkg::AddrW-1:0];
    wr_req.data = in_val;
  end

  logic                              start;
  logic [b5mv_pkg::RowW-1:0]         row_q;
  logic [b5mv_pkg::OffsetW-1:0]      k_q;
  logic [4:0]                        en_q;
  logic [b5mv_pkg::TermW-1:0]        term_q, term_d;

  assign start = in_acc && in_cmd == b5mv_pkg::CmdCompute && row_ok;

  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q <= in_idx;
      k_q   <= k_eff;
      en_q  <= en_d;
    end
  end

  // Term sequencer: one band read and one vector read per cycle.
  b5mv_pkg::rd_req_t rd_req;
  b5mv_pkg::term_t   term_iss;
  b5mv_pkg::term_t   term_meta_q;
  logic [b5mv_pkg::AddrW-1:0] row_a;
  logic [b5mv_pkg::AddrW-1:0] k_a;

  assign row_a = row_q[b5mv_pkg::AddrW-1:0];
  assign k_a   = k_q[b5mv_pkg::AddrW-1:0];

  always_comb begin
    rd_req.en        = state_q == StIssue;
    rd_req.band      = b5mv_pkg::BandMain;
    rd_req.band_addr = row_a;
    rd_req.vec_addr  = row_a;
    case (term_q)
      b5mv_pkg::TermFarLow: begin
        rd_req.band      = b5mv_pkg::BandFar;
        rd_req.band_addr = row_a - k_a;
        rd_req.vec_addr  = row_a - k_a;
      end
      b5mv_pkg::TermFarHigh: begin
        rd_req.band     = b5mv_pkg::BandFar;
        rd_req.vec_addr = row_a + k_a;
      end
      b5mv_pkg::TermNearLow: begin
        rd_req.band      = b5mv_pkg::BandNear;
        rd_req.band_addr = row_a - b5mv_pkg::AddrW'(1);
        rd_req.vec_addr  = row_a - b5mv_pkg::AddrW'(1);
      end
      b5mv_pkg::TermNearHigh: begin
        rd_req.band     = b5mv_pkg::BandNear;
        rd_req.vec_addr = row_a + b5mv_pkg::AddrW'(1);
      end
      default: ;
    endcase
    term_iss.valid = rd_req.en;
    term_iss.en    = (term_q <= b5mv_pkg::TermMain) ? en_q[term_q] : 1'b0;
    term_iss.first = term_q == b5mv_pkg::TermFarLow;
    term_iss.last  = term_q == b5mv_pkg::TermMain;
  end

  // The term tag is registered alongside the memory read, so it arrives with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_meta_q <= '0;
    end else begin
      term_meta_q <= term_iss;
    end
  end

  logic [b5mv_pkg::DataW-1:0] band_data;
  logic [b5mv_pkg::DataW-1:0] vec_data;
  logic                       mac_done;
  logic [b5mv_pkg::ProdW-1:0] mac_sum;

  b5mv_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr_req),
    .rd_i        (rd_req),
    .band_data_o (band_data),
    .vec_data_o  (vec_data)
  );

  b5mv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_i      (term_meta_q),
    .band_data_i (band_data),
    .vec_data_i  (vec_data),
    .done_o      (mac_done),
    .sum_o       (mac_sum)
  );

  // Output register; it is free when empty or being taken this cycle.
  logic                        out_valid_q;
  logic [b5mv_pkg::RowW-1:0]   out_row_q;
  logic [b5mv_pkg::ProdW-1:0]  out_val_q;
  logic                        out_free;
  logic                        out_load;

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = ((state_q == StDrain && mac_done) || state_q == StHold) && out_free;

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StIssue;
          term_d  = b5mv_pkg::TermFarLow;
        end
      end
      StIssue: begin
        if (term_q == b5mv_pkg::TermMain) begin
          state_d = StDrain;
        end else begin
          term_d = term_q + b5mv_pkg::TermW'(1);
        end
      end
      StDrain: begin
        if (mac_done) begin
          state_d = out_free ? StIdle : StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      term_q      <= b5mv_pkg::TermFarLow;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q <= row_q;
      out_val_q <= mac_sum;
    end
  end

  assign s_axis_tready = state_q == StIdle;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(b5mv_pkg::OutDataW - b5mv_pkg::ProdW - b5mv_pkg::RowW){1'b0}},
                          out_val_q, out_row_q};

endmodule

`default_nettype wire

@@ rtl/b5mv_store.sv @@
`default_nettype none

module b5mv_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire b5mv_pkg::wr_req_t             wr_i,
  input  wire b5mv_pkg::rd_req_t             rd_i,
  output logic     [b5mv_pkg::DataW-1:0]     band_data_o,
  output logic     [b5mv_pkg::DataW-1:0]     vec_data_o
);

  logic [b5mv_pkg::DataW-1:0] main_mem [b5mv_pkg::MaxOrder];
  logic [b5mv_pkg::DataW-1:0] near_mem [b5mv_pkg::MaxOrder];
  logic [b5mv_pkg::DataW-1:0] far_mem  [b5mv_pkg::MaxOrder];
  logic [b5mv_pkg::DataW-1:0] vec_mem  [b5mv_pkg::MaxOrder];

  logic [b5mv_pkg::DataW-1:0] main_q;
  logic [b5mv_pkg::DataW-1:0] near_q;
  logic [b5mv_pkg::DataW-1:0] far_q;
  logic [b5mv_pkg::DataW-1:0] vec_q;
  b5mv_pkg::band_e            band_sel_q;

  // Each store is single ported: a load or a read in any one cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.cmd == b5mv_pkg::CmdMain) begin
      main_mem[wr_i.addr] <= wr_i.data;
    end else if (rd_i.en) begin
      main_q <= main_mem[rd_i.band_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.cmd == b5mv_pkg::CmdNear) begin
      near_mem[wr_i.addr] <= wr_i.data;
    end else if (rd_i.en) begin
      near_q <= near_mem[rd_i.band_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.cmd == b5mv_pkg::CmdFar) begin
      far_mem[wr_i.addr] <= wr_i.data;
    end else if (rd_i.en) begin
      far_q <= far_mem[rd_i.band_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.cmd == b5mv_pkg::CmdVector) begin
      vec_mem[wr_i.addr] <= wr_i.data;
    end else if (rd_i.en) begin
      vec_q <= vec_mem[rd_i.vec_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_sel_q <= b5mv_pkg::BandMain;
    end else if (rd_i.en) begin
      band_sel_q <= rd_i.band;
    end
  end

  always_comb begin
    unique case (band_sel_q)
      b5mv_pkg::BandNear: band_data_o = near_q;
      b5mv_pkg::BandFar:  band_data_o = far_q;
      default:            band_data_o = main_q;
    endcase
  end

  assign vec_data_o = vec_q;

endmodule

`default_nettype wire

@@ rtl/b5mv_mac.sv @@
`default_nettype none

module b5mv_mac (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire b5mv_pkg::term_t                   term_i,
  input  wire logic     [b5mv_pkg::DataW-1:0]    band_data_i,
  input  wire logic     [b5mv_pkg::DataW-1:0]    vec_data_i,
  output logic                                   done_o,
  output logic     [b5mv_pkg::ProdW-1:0]         sum_o
);

  logic signed [b5mv_pkg::DataW-1:0] band_s;
  logic signed [b5mv_pkg::DataW-1:0] vec_s;
  logic signed [b5mv_pkg::ProdW-1:0] prod_full;
  logic signed [b5mv_pkg::ProdW-1:0] prod_d;
  logic signed [b5mv_pkg::ProdW-1:0] prod_q;
  b5mv_pkg::term_t                   pterm_q;
  logic signed [b5mv_pkg::AccW-1:0]  prod_ext;
  logic signed [b5mv_pkg::AccW-1:0]  acc_q;
  logic                              done_q;
  logic                              fits;

  assign band_s = band_data_i;
  assign vec_s  = vec_data_i;
  // The product is formed on its own so that it stays a signed multiply.
  assign prod_full = band_s * vec_s;
  // Skipped terms enter the sum as zero.
  assign prod_d = term_i.en ? prod_full : '0;

  always_ff @(posedge clk_i) begin
    if (term_i.valid) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pterm_q <= '0;
      done_q  <= 1'b0;
    end else begin
      pterm_q <= term_i;
      done_q  <= pterm_q.valid && pterm_q.last;
    end
  end

  assign prod_ext = {{(b5mv_pkg::AccW - b5mv_pkg::ProdW){prod_q[b5mv_pkg::ProdW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (pterm_q.valid) begin
      acc_q <= pterm_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  // The sum fits in 64 bits when all headroom bits copy bit 63.
  assign fits = (acc_q[b5mv_pkg::AccW-1:b5mv_pkg::ProdW-1] == '0) ||
                (acc_q[b5mv_pkg::AccW-1:b5mv_pkg::ProdW-1] == '1);

  always_comb begin
    if (fits) begin
      sum_o = acc_q[b5mv_pkg::ProdW-1:0];
    end else if (acc_q[b5mv_pkg::AccW-1]) begin
      sum_o = {1'b1, {(b5mv_pkg::ProdW-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(b5mv_pkg::ProdW-1){1'b1}}};
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire
